[rtl/core/ksa_pkg.sv]
// shared types, constants and key encoder for the key scan auto-repeat unit
`default_nettype none

package ksa_pkg;

	localparam int unsigned NUM_KEYS      = 6;
	localparam int unsigned CODE_W        = 3;
	localparam int unsigned COUNT_W       = 8;
	localparam int unsigned CFG_IDX_W     = 1;

	localparam logic [COUNT_W-1:0] HOLD_DELAY_RESET      = 8'd25;
	localparam logic [COUNT_W-1:0] REPEAT_INTERVAL_RESET = 8'd3;

	localparam logic [CODE_W-1:0] KEY_CODE_NONE = 3'd0;
	localparam logic [CODE_W-1:0] KEY_CODE_MAX  = 3'd6;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_HOLD_DELAY      = 1'b0,
		CFG_REPEAT_INTERVAL = 1'b1
	} cfg_index_t;

	typedef enum logic {
		MODE_SCAN = 1'b0,
		MODE_TICK = 1'b1
	} mode_t;

	typedef struct packed {
		logic [NUM_KEYS-1:0] last_pressed;
		logic [COUNT_W-1:0]  hold_count;
		logic [COUNT_W-1:0]  repeat_count;
	} scan_state_t;

	typedef struct packed {
		logic [COUNT_W-1:0] hold_delay_ticks;
		logic [COUNT_W-1:0] repeat_interval_ticks;
	} scan_cfg_t;

	// highest pressed key, plus one; zero when nothing is pressed
	function automatic logic [CODE_W-1:0] top_key_code(input logic [NUM_KEYS-1:0] keys);
		logic [CODE_W-1:0] code;
		code = KEY_CODE_NONE;
		for (int i = 0; i < NUM_KEYS; i++) begin
			if (keys[i]) begin
				code = CODE_W'(i + 1);
			end
		end
		return code;
	endfunction

endpackage

`default_nettype wire

[rtl/core/ksa_cfg_regs.sv]
// configuration registers: hold delay and repeat interval
`default_nettype none

module ksa_cfg_regs (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [ksa_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [ksa_pkg::COUNT_W-1:0]   cfg_data,
	output ksa_pkg::scan_cfg_t                 cfg
);

	ksa_pkg::scan_cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.hold_delay_ticks      <= ksa_pkg::HOLD_DELAY_RESET;
			cfg_q.repeat_interval_ticks <= ksa_pkg::REPEAT_INTERVAL_RESET;
		end else if (cfg_valid) begin
			case (ksa_pkg::cfg_index_t'(cfg_index))
				ksa_pkg::CFG_HOLD_DELAY: begin
					cfg_q.hold_delay_ticks <= cfg_data;
				end
				ksa_pkg::CFG_REPEAT_INTERVAL: begin
					cfg_q.repeat_interval_ticks <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

endmodule

`default_nettype wire

[rtl/core/ksa_step.sv]
// next-state and key code logic for one scan or tick item
`default_nettype none

module ksa_step (
	input  wire logic                         mode,
	input  wire logic [ksa_pkg::NUM_KEYS-1:0] keys,
	input  wire ksa_pkg::scan_state_t         cur,
	input  wire ksa_pkg::scan_cfg_t           cfg,
	output ksa_pkg::scan_state_t              nxt,
	output logic [ksa_pkg::CODE_W-1:0]        code
);

	logic new_key;
	logic overlap;
	logic expired;

	assign new_key = |(keys & ~cur.last_pressed);
	assign overlap = |(keys & cur.last_pressed);
	assign expired = (cur.hold_count == '0) && (cur.repeat_count == '0);

	always_comb begin
		nxt  = cur;
		code = ksa_pkg::KEY_CODE_NONE;
		case (ksa_pkg::mode_t'(mode))
			ksa_pkg::MODE_TICK: begin
				if (cur.hold_count != '0) begin
					nxt.hold_count = cur.hold_count - 1'b1;
				end
				if (cur.repeat_count != '0) begin
					nxt.repeat_count = cur.repeat_count - 1'b1;
				end
			end
			ksa_pkg::MODE_SCAN: begin
				nxt.last_pressed = keys;
				if (new_key) begin
					nxt.hold_count = cfg.hold_delay_ticks;
					code           = ksa_pkg::top_key_code(keys);
				end else if (overlap) begin
					if (expired) begin
						nxt.repeat_count = cfg.repeat_interval_ticks;
						code             = ksa_pkg::top_key_code(keys);
					end
				end else begin
					nxt.hold_count = cfg.hold_delay_ticks;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire

[rtl/core/key_scan_autorepeat_unit.sv]
// top level of the six-key scanner with hold delay and auto-repeat
//
//   channel | valid     | ready     | payload
//   --------+-----------+-----------+----------------------
//   in      | in_valid  | in_ready  | mode, pressed_keys
//   out     | out_valid | out_ready | key_code
//   cfg     | cfg_valid | cfg_ready | cfg_index, cfg_data
//
// one item per cycle while out_ready is high; key_code is held in the result register
// items pass an input register, then the scan logic and state update, then the result register
// the state update happens as an item moves into the result register
// a stalled result register holds the input register; in_ready falls only when both are full
// reset clears valid flags, scan state and loads the default delays; cfg_ready is always high
`default_nettype none

module key_scan_autorepeat_unit (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic                          mode,
	input  wire logic [ksa_pkg::NUM_KEYS-1:0]  pressed_keys,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [ksa_pkg::CODE_W-1:0]         key_code,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [ksa_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [ksa_pkg::COUNT_W-1:0]   cfg_data
);

	logic                         valid_s1;
	logic                         mode_s1;
	logic [ksa_pkg::NUM_KEYS-1:0] keys_s1;
	logic                         valid_s2;
	logic [ksa_pkg::CODE_W-1:0]   code_s2;

	ksa_pkg::scan_state_t         state_q;
	ksa_pkg::scan_state_t         state_nxt;
	ksa_pkg::scan_cfg_t           cfg;
	logic [ksa_pkg::CODE_W-1:0]   code_nxt;

	logic                         out_free;
	logic                         adv_s1;
	logic                         in_take;

	assign out_free = !valid_s2 || out_ready;
	assign adv_s1   = valid_s1 && out_free;
	assign in_ready = !valid_s1 || out_free;
	assign in_take  = in_valid && in_ready;

	assign out_valid = valid_s2;
	assign key_code  = code_s2;

	ksa_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	ksa_step u_step (
		.mode (mode_s1),
		.keys (keys_s1),
		.cur  (state_q),
		.cfg  (cfg),
		.nxt  (state_nxt),
		.code (code_nxt)
	);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			mode_s1 <= mode;
			keys_s1 <= pressed_keys;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_free) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			code_s2 <= code_nxt;
		end
	end

	// scan state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (adv_s1) begin
			state_q <= state_nxt;
		end
	end

`ifndef SYNTHESIS
	a_code_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (key_code <= ksa_pkg::KEY_CODE_MAX))
		else $error("key code out of range");

	a_tick_no_code: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && (mode_s1 == ksa_pkg::MODE_TICK)) |=> (key_code == ksa_pkg::KEY_CODE_NONE))
		else $error("tick item gave a key code");

	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv_s1 |=> $stable(state_q))
		else $error("scan state changed without an item");

	a_tick_keeps_keys: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && (mode_s1 == ksa_pkg::MODE_TICK))
			|=> (state_q.last_pressed == $past(state_q.last_pressed)))
		else $error("tick changed the pressed set");
`endif

endmodule

`default_nettype wire
